>>> hw/rtl/rbp_pkg.sv
package rbp_pkg;

  // configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_WIDTH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_HEIGHT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_X      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_Y      = 3'd4;

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // field widths
  localparam int ADDR_W   = 12;
  localparam int ROW_W    = 8;
  localparam int COL_W    = 4;
  localparam int BIT_W    = 3;
  localparam int COORD_W  = 16;
  localparam int DIM_W    = 11;
  localparam int PROD_W   = 2 * DIM_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int IDX_W    = SUM_W - BIT_W;

  // register reset values
  localparam logic [1:0]         ROTATION_RST      = ROT_0;
  localparam logic [DIM_W-1:0]   BUFFER_WIDTH_RST  = 11'd128;
  localparam logic [DIM_W-1:0]   BUFFER_HEIGHT_RST = 11'd256;
  localparam logic [COORD_W-1:0] WINDOW_RST        = 16'd0;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic issue;
    logic write;
    logic load_out;
  } rbp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic issue_last;
    logic acc_full;
  } rbp_status_t;

endpackage

>>> hw/rtl/rbp_ctrl.sv
module rbp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                func,
  output logic                result_valid,
  input  logic                result_stall,
  output rbp_pkg::rbp_cmd_t   cmd,
  input  rbp_pkg::rbp_status_t status
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DRAIN
  } state_t;

  state_t state;

  logic accept;
  logic out_free;

  // accept only while idle
  assign item_stall = (state != IDLE);
  assign accept     = item_valid && (state == IDLE);
  assign out_free   = !result_valid || !result_stall;

  // commands to the datapath
  always_comb begin
    cmd.write    = accept && (func == rbp_pkg::FUNC_WRITE);
    cmd.latch    = accept && (func == rbp_pkg::FUNC_READ);
    cmd.issue    = (state == RUN);
    cmd.load_out = (state == DRAIN) && status.acc_full && out_free;
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      // set on load, cleared once the beat is taken
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd.latch) begin
            state <= RUN;
          end
        end
        RUN: begin
          if (status.issue_last) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (cmd.load_out) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/rbp_datapath.sv
module rbp_datapath #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 256,
  parameter int STORE_BYTES  = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic [rbp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rbp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [rbp_pkg::ADDR_W-1:0]          address,
  input  logic [7:0]                          write_data,
  input  logic [rbp_pkg::ROW_W-1:0]           row,
  input  logic [rbp_pkg::COL_W-1:0]           column_byte,
  output logic [7:0]                          packed_byte,
  input  rbp_pkg::rbp_cmd_t                   cmd,
  output rbp_pkg::rbp_status_t                status
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [rbp_pkg::IDX_W-1:0]   STORE_LIMIT = rbp_pkg::IDX_W'(STORE_BYTES);
  localparam logic [rbp_pkg::COORD_W-1:0] PW = rbp_pkg::COORD_W'(PANEL_WIDTH);
  localparam logic [rbp_pkg::COORD_W-1:0] PH = rbp_pkg::COORD_W'(PANEL_HEIGHT);

  // configuration registers
  logic [1:0]                     rotation;
  logic [rbp_pkg::DIM_W-1:0]      buffer_width;
  logic [rbp_pkg::DIM_W-1:0]      buffer_height;
  logic [rbp_pkg::COORD_W-1:0]    window_x;
  logic [rbp_pkg::COORD_W-1:0]    window_y;

  // item registers
  logic [rbp_pkg::ROW_W-1:0]      row_q;
  logic [rbp_pkg::COL_W-1:0]      col_q;
  logic [rbp_pkg::BIT_W-1:0]      pix;
  logic [rbp_pkg::BIT_W-1:0]      cap;
  logic                           acc_full;
  logic [7:0]                     acc;

  // pixel pipeline
  logic                           v1, v2, v3;
  logic [rbp_pkg::COORD_W-1:0]    x1, y1;
  logic [rbp_pkg::COORD_W-1:0]    xm, ym;
  logic [rbp_pkg::COORD_W-1:0]    p16, i16;
  logic [rbp_pkg::PROD_W-1:0]     prod;
  logic [rbp_pkg::DIM_W-1:0]      x2;
  logic                           ok2, ok3;
  logic [rbp_pkg::SUM_W-1:0]      sum;
  logic [rbp_pkg::IDX_W-1:0]      idx;
  logic                           ok_idx;
  logic [rbp_pkg::BIT_W-1:0]      xsel3;
  logic [7:0]                     rdata;
  logic [rbp_pkg::IDX_W-1:0]      waddr;

  logic [7:0] mem [STORE_BYTES];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation      <= rbp_pkg::ROTATION_RST;
      buffer_width  <= rbp_pkg::BUFFER_WIDTH_RST;
      buffer_height <= rbp_pkg::BUFFER_HEIGHT_RST;
      window_x      <= rbp_pkg::WINDOW_RST;
      window_y      <= rbp_pkg::WINDOW_RST;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        rbp_pkg::REG_ROTATION:      rotation      <= cfg_data[1:0];
        rbp_pkg::REG_BUFFER_WIDTH:  buffer_width  <= cfg_data[rbp_pkg::DIM_W-1:0];
        rbp_pkg::REG_BUFFER_HEIGHT: buffer_height <= cfg_data[rbp_pkg::DIM_W-1:0];
        rbp_pkg::REG_WINDOW_X:      window_x      <= cfg_data;
        rbp_pkg::REG_WINDOW_Y:      window_y      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // frame store write, addresses past the store are dropped
  assign waddr = rbp_pkg::IDX_W'(address);

  always_ff @(posedge clk) begin
    if (cmd.write && (waddr < STORE_LIMIT)) begin
      mem[waddr[AW-1:0]] <= write_data;
    end
  end

  // item capture and pixel counters
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      row_q <= row;
      col_q <= column_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix      <= '0;
      cap      <= '0;
      acc_full <= 1'b0;
    end else if (cmd.latch) begin
      pix      <= '0;
      cap      <= '0;
      acc_full <= 1'b0;
    end else begin
      if (cmd.issue) begin
        pix <= pix + 1'b1;
      end
      if (v3) begin
        cap <= cap + 1'b1;
        if (cap == '1) begin
          acc_full <= 1'b1;
        end
      end
    end
  end

  assign status.issue_last = cmd.issue && (pix == '1);
  assign status.acc_full   = acc_full;

  // stage 0: panel position through the rotation
  assign p16 = rbp_pkg::COORD_W'({col_q, pix});
  assign i16 = rbp_pkg::COORD_W'(row_q);

  always_comb begin
    case (rotation)
      rbp_pkg::ROT_0: begin
        xm = p16;
        ym = i16;
      end
      rbp_pkg::ROT_90: begin
        xm = PH - i16 - 16'd1;
        ym = p16;
      end
      rbp_pkg::ROT_180: begin
        xm = PW - p16 - 16'd1;
        ym = PH - i16 - 16'd1;
      end
      default: begin
        xm = i16;
        ym = PW - p16 - 16'd1;
      end
    endcase
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // stage 0 to 1: window offset, 16-bit wrap
  always_ff @(posedge clk) begin
    x1 <= xm + window_x;
    y1 <= ym + window_y;
  end

  // stage 1 to 2: bounds check and row multiply
  always_ff @(posedge clk) begin
    ok2  <= (x1 < rbp_pkg::COORD_W'(buffer_width)) &&
            (y1 < rbp_pkg::COORD_W'(buffer_height));
    prod <= rbp_pkg::PROD_W'(y1[rbp_pkg::DIM_W-1:0]) * rbp_pkg::PROD_W'(buffer_width);
    x2   <= x1[rbp_pkg::DIM_W-1:0];
  end

  // stage 2: byte index and store read
  assign sum    = rbp_pkg::SUM_W'(prod) + rbp_pkg::SUM_W'(x2);
  assign idx    = sum[rbp_pkg::SUM_W-1:rbp_pkg::BIT_W];
  assign ok_idx = ok2 && (idx < STORE_LIMIT);

  always_ff @(posedge clk) begin
    rdata <= mem[idx[AW-1:0]];
    ok3   <= ok_idx;
    xsel3 <= x2[rbp_pkg::BIT_W-1:0];
  end

  // stage 3: pick the bit, first pixel ends up in the msb
  always_ff @(posedge clk) begin
    if (v3) begin
      acc <= {acc[6:0], ok3 & rdata[xsel3]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      packed_byte <= acc;
    end
  end

endmodule

>>> hw/rtl/rotated_bitplane_packer.sv
// a read item issues its eight pixels into the store pipeline one per cycle, then the
// pipeline drains and the result register loads once the output is free; a new item
// is taken in the cycle after the result register loads
// a write item can be accepted every cycle while no read is in flight
// reset: synchronous, clears control and restores register defaults
// frame store contents stay undefined until written
module rotated_bitplane_packer #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 256,
  parameter int STORE_BYTES  = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_enable,
  input  logic [rbp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rbp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            func,
  input  logic [rbp_pkg::ADDR_W-1:0]      address,
  input  logic [7:0]                      write_data,
  input  logic [rbp_pkg::ROW_W-1:0]       row,
  input  logic [rbp_pkg::COL_W-1:0]       column_byte,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [7:0]                      packed_byte
);

  rbp_pkg::rbp_cmd_t    cmd;
  rbp_pkg::rbp_status_t status;

  // sequencer
  rbp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  // store, rotation mapping and pixel pipeline
  rbp_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .STORE_BYTES  (STORE_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .address          (address),
    .write_data       (write_data),
    .row              (row),
    .column_byte      (column_byte),
    .packed_byte      (packed_byte),
    .cmd              (cmd),
    .status           (status)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int PANEL_W     = 128;
  localparam int PANEL_H     = 256;
  localparam int STORE_BYTES = 4096;
  localparam int IDLE_LIMIT  = 3000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 20;

  // one beat on the item channel
  typedef struct {
    logic                       fn;
    logic [rbp_pkg::ADDR_W-1:0] addr;
    logic [7:0]                 data;
    logic [rbp_pkg::ROW_W-1:0]  r;
    logic [rbp_pkg::COL_W-1:0]  c;
  } pixel_op_t;

  logic                            clk;
  logic                            rst              = 1'b1;
  logic                            cfg_write_enable = 1'b0;
  logic [rbp_pkg::CFG_INDEX_W-1:0] cfg_index        = '0;
  logic [rbp_pkg::CFG_DATA_W-1:0]  cfg_data         = '0;
  logic                            item_valid       = 1'b0;
  logic                            item_stall;
  logic                            func             = rbp_pkg::FUNC_WRITE;
  logic [rbp_pkg::ADDR_W-1:0]      address          = '0;
  logic [7:0]                      write_data       = '0;
  logic [rbp_pkg::ROW_W-1:0]       row              = '0;
  logic [rbp_pkg::COL_W-1:0]       column_byte      = '0;
  logic                            result_valid;
  logic                            result_stall     = 1'b0;
  logic [7:0]                      packed_byte;

  // register copies seen by the predictor
  logic [1:0]                  rot_cfg    = rbp_pkg::ROTATION_RST;
  logic [rbp_pkg::DIM_W-1:0]   width_cfg  = rbp_pkg::BUFFER_WIDTH_RST;
  logic [rbp_pkg::DIM_W-1:0]   height_cfg = rbp_pkg::BUFFER_HEIGHT_RST;
  logic [rbp_pkg::COORD_W-1:0] winx_cfg   = rbp_pkg::WINDOW_RST;
  logic [rbp_pkg::COORD_W-1:0] winy_cfg   = rbp_pkg::WINDOW_RST;

  logic [7:0] frame_copy [STORE_BYTES];
  bit         planned    [STORE_BYTES];
  pixel_op_t  op_queue [$];
  logic [7:0] packed_due [$];
  pixel_op_t  next_op;

  bit steady = 1'b0;
  int gap_left;
  int stall_left;
  int results_taken;
  int idle_cycles;
  int mismatch_count = 0;
  int bytes_checked  = 0;
  int ops_taken      = 0;
  int settings_used  = 0;

  rotated_bitplane_packer #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H),
    .STORE_BYTES (STORE_BYTES)
  ) uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .func            (func),
    .address         (address),
    .write_data      (write_data),
    .row             (row),
    .column_byte     (column_byte),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .packed_byte     (packed_byte)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // store byte holding panel pixel b of (r, c), -1 when it reads as zero
  function automatic int locate_pixel(input int r, input int c, input int b,
                                      output int bitpos);
    int p, px, py;
    longint idx;
    logic [15:0] x, y;
    p = 8 * c + b;
    case (rot_cfg)
      rbp_pkg::ROT_0: begin
        px = p;
        py = r;
      end
      rbp_pkg::ROT_90: begin
        px = PANEL_H - r - 1;
        py = p;
      end
      rbp_pkg::ROT_180: begin
        px = PANEL_W - p - 1;
        py = PANEL_H - r - 1;
      end
      default: begin
        px = r;
        py = PANEL_W - p - 1;
      end
    endcase
    x = 16'(px + int'(winx_cfg));
    y = 16'(py + int'(winy_cfg));
    bitpos = int'(x[2:0]);
    if (x >= width_cfg || y >= height_cfg) return -1;
    idx = (longint'(y) * longint'(width_cfg) + longint'(x)) >> 3;
    if (idx >= STORE_BYTES) return -1;
    return int'(idx);
  endfunction

  // eight rotated pixels, first one in the msb
  function automatic logic [7:0] packed_pixels(input int r, input int c);
    logic [7:0] acc;
    int idx, bitpos, b;
    acc = '0;
    for (b = 0; b < 8; b++) begin
      idx = locate_pixel(r, c, b, bitpos);
      acc = {acc[6:0], (idx >= 0) ? frame_copy[idx][bitpos] : 1'b0};
    end
    return acc;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 1024;
    if (r == 2) return $urandom_range(1, 1024);
    return $urandom_range(1, 256);
  endfunction

  function automatic int pick_window();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 7) return $urandom_range(0, 255);
    if (r < 9) return 65536 - $urandom_range(1, 256);
    return $urandom_range(0, 65535);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 50) $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  task automatic queue_write(input int a, input logic [7:0] d);
    pixel_op_t op;
    planned[a] = 1'b1;
    op.fn   = rbp_pkg::FUNC_WRITE;
    op.addr = rbp_pkg::ADDR_W'(a);
    op.data = d;
    op.r    = rbp_pkg::ROW_W'($urandom);
    op.c    = rbp_pkg::COL_W'($urandom);
    op_queue.push_back(op);
  endtask

  // fills any store byte the read would touch before the read itself
  task automatic queue_read(input int r, input int c);
    pixel_op_t op;
    int idx, bitpos, b;
    for (b = 0; b < 8; b++) begin
      idx = locate_pixel(r, c, b, bitpos);
      if (idx >= 0 && !planned[idx]) queue_write(idx, 8'($urandom));
    end
    op.fn   = rbp_pkg::FUNC_READ;
    op.addr = rbp_pkg::ADDR_W'($urandom);
    op.data = 8'($urandom);
    op.r    = rbp_pkg::ROW_W'(r);
    op.c    = rbp_pkg::COL_W'(c);
    op_queue.push_back(op);
  endtask

  // queues about n beats, fill writes included
  task automatic run_random(input int n);
    int span;
    span = (int'(width_cfg) * int'(height_cfg)) / 8;
    if (span < 1) span = 1;
    if (span > STORE_BYTES) span = STORE_BYTES;
    while (op_queue.size() < n) begin
      if ($urandom_range(0, 1)) queue_read($urandom_range(0, 255), $urandom_range(0, 15));
      else if ($urandom_range(0, 9) < 7) queue_write($urandom_range(0, span - 1), 8'($urandom));
      else queue_write($urandom_range(0, STORE_BYTES - 1), 8'($urandom));
    end
  endtask

  task automatic put_reg(input logic [rbp_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [rbp_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= val;
  endtask

  task automatic set_regs(input logic [1:0] rot, input int w, input int h,
                          input int wx, input int wy);
    rot_cfg    = rot;
    width_cfg  = rbp_pkg::DIM_W'(w);
    height_cfg = rbp_pkg::DIM_W'(h);
    winx_cfg   = rbp_pkg::COORD_W'(wx);
    winy_cfg   = rbp_pkg::COORD_W'(wy);
    put_reg(rbp_pkg::REG_ROTATION, rbp_pkg::CFG_DATA_W'(rot));
    put_reg(rbp_pkg::REG_BUFFER_WIDTH, rbp_pkg::CFG_DATA_W'(w));
    put_reg(rbp_pkg::REG_BUFFER_HEIGHT, rbp_pkg::CFG_DATA_W'(h));
    put_reg(rbp_pkg::REG_WINDOW_X, rbp_pkg::CFG_DATA_W'(wx));
    put_reg(rbp_pkg::REG_WINDOW_Y, rbp_pkg::CFG_DATA_W'(wy));
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  // wait until every beat is in and every byte is out, then let writes finish
  task automatic settle();
    do @(negedge clk);
    while (op_queue.size() != 0 || item_valid || packed_due.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // accepted item beat: update the store copy or predict the byte
  task automatic take_beat();
    if (func == rbp_pkg::FUNC_WRITE) begin
      if (address < STORE_BYTES) frame_copy[address] = write_data;
    end else begin
      packed_due.push_back(packed_pixels(row, column_byte));
    end
    ops_taken++;
  endtask

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (item_valid && !item_stall) take_beat();
      if (!(item_valid && item_stall)) begin
        if (gap_left > 0) begin
          item_valid <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (op_queue.size() != 0) begin
          next_op     = op_queue.pop_front();
          func        <= next_op.fn;
          address     <= next_op.addr;
          write_data  <= next_op.data;
          row         <= next_op.r;
          column_byte <= next_op.c;
          item_valid  <= 1'b1;
          gap_left    <= pick_gap();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result stall: random stalls plus two long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      result_stall  <= 1'b0;
      stall_left    <= 0;
      results_taken <= 0;
    end else begin
      if (result_valid && !result_stall) results_taken <= results_taken + 1;
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left   <= stall_left - 1;
      end else if (result_valid && !result_stall &&
                   (results_taken == 120 || results_taken == 700)) begin
        result_stall <= 1'b1;
        stall_left   <= LONG_HOLD - 1;
      end else if (steady) begin
        result_stall <= 1'b0;
      end else begin
        case ($urandom_range(0, 19)) inside
          [0:13]: result_stall <= 1'b0;
          [14:18]: begin
            result_stall <= 1'b1;
            stall_left   <= $urandom_range(0, 3);
          end
          default: begin
            result_stall <= 1'b1;
            stall_left   <= $urandom_range(8, 40);
          end
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (packed_due.size() == 0) begin
        report_mismatch($sformatf("unexpected packed byte %02h", packed_byte));
      end else begin
        if (packed_byte !== packed_due[0])
          report_mismatch($sformatf("packed byte %02h, predicted %02h",
                                    packed_byte, packed_due[0]));
        void'(packed_due.pop_front());
        bytes_checked++;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int ph, rot;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: byte extremes and panel corners
    queue_write(0, 8'hFF);
    queue_write(STORE_BYTES - 1, 8'h00);
    queue_read(0, 0);
    queue_read(255, 15);
    queue_read(0, 15);
    queue_read(255, 0);
    queue_write(STORE_BYTES - 1, 8'hA5);
    queue_read(255, 15);
    settle();

    // the other quarter turns
    for (rot = 1; rot < 4; rot++) begin
      set_regs(2'(rot), 128, 256, 0, 0);
      queue_read(0, 0);
      queue_read(255, 15);
      settle();
    end

    // a 1024 by 1024 buffer: rows far down index past the store
    set_regs(rbp_pkg::ROT_0, 1024, 1024, 0, 0);
    queue_read(255, 15);
    queue_read(3, 0);
    settle();

    // empty buffer reads all zero
    set_regs(rbp_pkg::ROT_0, 0, 0, 0, 0);
    queue_read(7, 7);
    settle();

    // window offsets wrap around
    set_regs(rbp_pkg::ROT_0, 128, 256, 65535, 65535);
    queue_read(0, 0);
    queue_read(1, 1);
    settle();

    // random phases over random settings
    for (ph = 0; ph < 10; ph++) begin
      set_regs(2'(ph % 4), pick_dim(), pick_dim(), pick_window(), pick_window());
      steady = (ph % 3 == 1);
      run_random(160);
      settle();
    end

    $display("%0d item beats accepted, %0d packed bytes checked over %0d register settings",
             ops_taken, bytes_checked, settings_used + 1);
    $display("all four rotations, empty and oversize buffers and wrapping windows exercised");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
